/* src/tes_pkg.sv */
// ----------------------------------------------------------------------------
// tes_pkg: shared types and constants for the touch event sampler
// Field widths and the request bundle passed to the per-axis scale units.
// ----------------------------------------------------------------------------
`default_nettype none

package tes_pkg;

  localparam int RAW_W = 12;   // raw converter sample
  localparam int SCR_W = 10;   // screen coordinate
  localparam int DIV_W = 16;   // serial divider width, holds raw*10 and step

  // Scale request: one start strobe plus the operands for one axis
  typedef struct packed {
    logic             start;
    logic [RAW_W-1:0] raw;
    logic [RAW_W-1:0] max_raw;
    logic [SCR_W-1:0] screen;
  } scale_req_t;

endpackage

`default_nettype wire

/* src/tes_scale.sv */
// ----------------------------------------------------------------------------
// tes_scale: per-axis coordinate scaling
// step = (max_raw / screen) * 10, coord = clamp((raw * 10) / step - 10).
// Both divisions run bit-serially on one shared restoring divider.
// ----------------------------------------------------------------------------
`default_nettype none

module tes_scale import tes_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire scale_req_t       req,
  output logic                  done,
  output logic [SCR_W-1:0]      coord
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV1,
    S_STEP,
    S_DIV2,
    S_FIN
  } state_t;

  state_t           state;
  logic [3:0]       cnt;
  logic [DIV_W-1:0] dq;       // dividend in, quotient out
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvsr;
  logic [RAW_W-1:0] raw_q;
  logic [SCR_W-1:0] screen_q;
  logic             scr_zero;
  logic             step_zero;

  // one restoring step
  logic [DIV_W:0]   rem_sh;
  logic [DIV_W:0]   rem_sub;
  logic             ge;
  logic [DIV_W-1:0] rem_next;
  logic [DIV_W-1:0] dq_next;

  always_comb begin
    rem_sh   = {rem, dq[DIV_W-1]};
    ge       = rem_sh >= {1'b0, dvsr};
    rem_sub  = rem_sh - {1'b0, dvsr};
    rem_next = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    dq_next  = {dq[DIV_W-2:0], ge};
  end

  // x*10 as two shifted adds
  logic [DIV_W-1:0] step10;
  logic [DIV_W-1:0] raw10;
  assign step10 = {1'b0, dq[RAW_W-1:0], 3'b000} + {3'b000, dq[RAW_W-1:0], 1'b0};
  assign raw10  = {1'b0, raw_q, 3'b000} + {3'b000, raw_q, 1'b0};

  // clamp of quotient - 10 to 0..screen
  logic             q_low;
  logic [DIV_W-1:0] q_off;
  logic             q_over;
  assign q_low  = dq < DIV_W'(10);
  assign q_off  = dq - DIV_W'(10);
  assign q_over = q_off > {{(DIV_W-SCR_W){1'b0}}, screen_q};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.start) begin
            raw_q    <= req.raw;
            screen_q <= req.screen;
            scr_zero <= (req.screen == '0);
            dq       <= {req.max_raw, {(DIV_W-RAW_W){1'b0}}};
            rem      <= '0;
            dvsr     <= {{(DIV_W-SCR_W){1'b0}}, req.screen};
            cnt      <= 4'(RAW_W - 1);
            state    <= S_DIV1;
          end
        end
        S_DIV1: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt - 4'd1;
          if (cnt == '0) state <= S_STEP;
        end
        S_STEP: begin
          // quotient of the first division sits in the low bits
          step_zero <= (dq[RAW_W-1:0] == '0);
          dvsr      <= step10;
          dq        <= raw10;
          rem       <= '0;
          cnt       <= 4'(DIV_W - 1);
          state     <= S_DIV2;
        end
        S_DIV2: begin
          dq  <= dq_next;
          rem <= rem_next;
          cnt <= cnt - 4'd1;
          if (cnt == '0) state <= S_FIN;
        end
        S_FIN: begin
          if (scr_zero)       coord <= '0;
          else if (step_zero) coord <= screen_q;
          else if (q_low)     coord <= '0;
          else if (q_over)    coord <= screen_q;
          else                coord <= q_off[SCR_W-1:0];
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/touch_event_sampler_core.sv */
// ----------------------------------------------------------------------------
// touch_event_sampler_core: timer-sampled resistive touch press/release detector
// Accumulates tick time, samples pen state once per period, tracks the touch
// state and reports events with scaled X/Y coordinates.
// ----------------------------------------------------------------------------
// One item in, one item out. Each tick adds its elapsed time to a 32-bit
// saturating accumulator; when the accumulator reaches sample_period one period
// is taken off and the pen is sampled (due). Pen down stores the raw X/Y samples
// and moves untouched to touched; pen up moves touched to released and released
// to untouched; each change sets event_valid with its event_kind. Every result
// carries coordinates scaled from the stored raw samples with the current
// registers. After acceptance the item is accumulated and evaluated, then
// scaled by the two scale units (one per axis, in lockstep): each runs a
// 12-step and then a 16-step radix-2 restoring division, one quotient bit
// per cycle, with a setup before each division and a finish step, and the
// result is then handed over to the output register. in_stall is high from
// acceptance until the result is loaded into the output register, so no new
// item is taken before then; a loaded result may wait on out_stall while the
// next item is accepted. The user must write registers over the APB port
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_event_sampler_core import tes_pkg::*; #(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // item in
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [15:0]      elapsed,
  input  wire logic             pen_down,
  input  wire logic [RAW_W-1:0] sample_x,
  input  wire logic [RAW_W-1:0] sample_y,
  // item out
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  due,
  output logic                  pressed,
  output logic                  event_valid,
  output logic [1:0]            event_kind,
  output logic [SCR_W-1:0]      coord_x,
  output logic [SCR_W-1:0]      coord_y,
  output logic [RAW_W-1:0]      raw_x,
  output logic [RAW_W-1:0]      raw_y,
  output logic [1:0]            touch_state,
  // configuration
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // sample masking: keep SAMPLE_BITS, never more than the converter width
  localparam int KEEP_BITS = (SAMPLE_BITS < RAW_W) ? SAMPLE_BITS : RAW_W;
  localparam logic [RAW_W-1:0] SAMPLE_MASK = RAW_W'((32'd1 << KEEP_BITS) - 32'd1);

  // register map (word index)
  localparam logic [2:0] REG_MAX_RAW_X  = 3'd0;
  localparam logic [2:0] REG_MAX_RAW_Y  = 3'd1;
  localparam logic [2:0] REG_SCREEN_W   = 3'd2;
  localparam logic [2:0] REG_SCREEN_H   = 3'd3;
  localparam logic [2:0] REG_PERIOD     = 3'd4;

  // touch state codes
  localparam logic [1:0] PH_UNTOUCHED = 2'd0;
  localparam logic [1:0] PH_TOUCHED   = 2'd1;
  localparam logic [1:0] PH_RELEASED  = 2'd2;

  // event codes
  localparam logic [1:0] EV_TOUCHED   = 2'd0;
  localparam logic [1:0] EV_RELEASED  = 2'd1;
  localparam logic [1:0] EV_UNTOUCHED = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC,
    S_EVAL,
    S_SCALE,
    S_OUT
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [RAW_W-1:0] max_raw_x;
  logic [RAW_W-1:0] max_raw_y;
  logic [SCR_W-1:0] screen_width;
  logic [SCR_W-1:0] screen_height;
  logic [15:0]      sample_period;

  logic       cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_raw_x     <= RAW_W'(3942);
      max_raw_y     <= RAW_W'(3853);
      screen_width  <= SCR_W'(320);
      screen_height <= SCR_W'(240);
      sample_period <= 16'd20;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MAX_RAW_X: max_raw_x     <= pwdata[RAW_W-1:0];
        REG_MAX_RAW_Y: max_raw_y     <= pwdata[RAW_W-1:0];
        REG_SCREEN_W:  screen_width  <= pwdata[SCR_W-1:0];
        REG_SCREEN_H:  screen_height <= pwdata[SCR_W-1:0];
        REG_PERIOD:    sample_period <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MAX_RAW_X: prdata = {{(32-RAW_W){1'b0}}, max_raw_x};
      REG_MAX_RAW_Y: prdata = {{(32-RAW_W){1'b0}}, max_raw_y};
      REG_SCREEN_W:  prdata = {{(32-SCR_W){1'b0}}, screen_width};
      REG_SCREEN_H:  prdata = {{(32-SCR_W){1'b0}}, screen_height};
      REG_PERIOD:    prdata = {16'd0, sample_period};
      default:       prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Tick processing
  // --------------------------------------------------------------------------
  state_t           state;
  logic [31:0]      time_accum;
  logic [1:0]       phase;
  logic [RAW_W-1:0] stored_raw_x;
  logic [RAW_W-1:0] stored_raw_y;

  // latched item
  logic [15:0]      elapsed_q;
  logic             pen_q;
  logic [RAW_W-1:0] sx_q;
  logic [RAW_W-1:0] sy_q;

  // per-tick flags
  logic             due_q;
  logic             pressed_q;
  logic             ev_q;
  logic [1:0]       kind_q;
  logic             scale_go;

  logic             in_acc;
  logic [32:0]      acc_sum;
  logic [32:0]      acc_diff;
  logic             acc_due;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign acc_sum  = {1'b0, time_accum} + {17'd0, elapsed_q};
  // no borrow means accumulator >= period; a zero period always passes
  assign acc_diff = {1'b0, time_accum} - {17'd0, sample_period};
  assign acc_due  = ~acc_diff[32];

  // scale units, one per axis
  scale_req_t       req_x;
  scale_req_t       req_y;
  logic             done_x;
  logic             done_y;
  logic [SCR_W-1:0] cx;
  logic [SCR_W-1:0] cy;

  assign req_x = '{start: scale_go, raw: stored_raw_x, max_raw: max_raw_x,
                   screen: screen_width};
  assign req_y = '{start: scale_go, raw: stored_raw_y, max_raw: max_raw_y,
                   screen: screen_height};

  tes_scale u_scale_x (
    .clk   (clk),
    .rst   (rst),
    .req   (req_x),
    .done  (done_x),
    .coord (cx)
  );

  tes_scale u_scale_y (
    .clk   (clk),
    .rst   (rst),
    .req   (req_y),
    .done  (done_y),
    .coord (cy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      time_accum   <= '0;
      phase        <= PH_UNTOUCHED;
      stored_raw_x <= '0;
      stored_raw_y <= '0;
      scale_go     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      scale_go <= 1'b0;
      if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            elapsed_q <= elapsed;
            pen_q     <= pen_down;
            sx_q      <= sample_x & SAMPLE_MASK;
            sy_q      <= sample_y & SAMPLE_MASK;
            state     <= S_ACC;
          end
        end
        S_ACC: begin
          // saturating add
          time_accum <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
          state      <= S_EVAL;
        end
        S_EVAL: begin
          due_q     <= acc_due;
          pressed_q <= 1'b0;
          ev_q      <= 1'b0;
          kind_q    <= EV_TOUCHED;
          if (acc_due) begin
            time_accum <= acc_diff[31:0];
            if (pen_q) begin
              stored_raw_x <= sx_q;
              stored_raw_y <= sy_q;
              pressed_q    <= 1'b1;
              if (phase != PH_TOUCHED && phase != PH_RELEASED) begin
                phase  <= PH_TOUCHED;
                ev_q   <= 1'b1;
                kind_q <= EV_TOUCHED;
              end
            end else if (phase == PH_TOUCHED) begin
              phase  <= PH_RELEASED;
              ev_q   <= 1'b1;
              kind_q <= EV_RELEASED;
            end else if (phase == PH_RELEASED) begin
              phase  <= PH_UNTOUCHED;
              ev_q   <= 1'b1;
              kind_q <= EV_UNTOUCHED;
            end
          end
          scale_go <= 1'b1;
          state    <= S_SCALE;
        end
        S_SCALE: begin
          if (done_x) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            due         <= due_q;
            pressed     <= pressed_q;
            event_valid <= ev_q;
            event_kind  <= kind_q;
            coord_x     <= cx;
            coord_y     <= cy;
            raw_x       <= stored_raw_x;
            raw_y       <= stored_raw_y;
            touch_state <= phase;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // both axes run the same cycle count
  a_scale_lockstep: assert property (@(posedge clk) disable iff (rst)
    done_x == done_y)
    else $error("scale units out of step");

  // touch state only moves in the evaluate cycle
  a_phase_hold: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(state) != S_EVAL) |-> $stable(phase))
    else $error("touch state changed outside evaluation");

  // a tick that is not due reports nothing
  a_not_due_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !due) |-> (!pressed && !event_valid))
    else $error("press or event without a due sample");

  // a release event leaves the released state visible
  a_release_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_valid && event_kind == EV_RELEASED)
      |-> (touch_state == PH_RELEASED))
    else $error("release event with wrong touch state");

endmodule

`default_nettype wire

/* tb/touch_event_sampler_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_event_sampler_core_tb: self-checking bench for the touch event sampler
// Feeds timer ticks through the valid/stall item port, programs the scaling
// and period registers over APB between traffic phases, predicts every result
// item in the bench and compares each one field by field as it leaves.
// ----------------------------------------------------------------------------

module touch_event_sampler_core_tb;
  import tes_pkg::*;

  // Busy time of one item: two serial divisions per axis plus load.
  localparam int ITEM_CYCLES = 36;
  // Cycles with no item moving on either side before the run is abandoned.
  // Longest honest quiet stretch is the forced receiver hold-off plus one item.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  // Register map, index i at byte address 4*i
  typedef enum int {
    REG_MAX_RAW_X     = 0,
    REG_MAX_RAW_Y     = 1,
    REG_SCREEN_WIDTH  = 2,
    REG_SCREEN_HEIGHT = 3,
    REG_SAMPLE_PERIOD = 4
  } cfg_reg_e;

  // Touch states and event kinds as the block reports them
  localparam logic [1:0] ST_UNTOUCHED = 2'd0;
  localparam logic [1:0] ST_TOUCHED   = 2'd1;
  localparam logic [1:0] ST_RELEASED  = 2'd2;
  localparam logic [1:0] EV_TOUCHED   = 2'd0;
  localparam logic [1:0] EV_RELEASED  = 2'd1;
  localparam logic [1:0] EV_UNTOUCHED = 2'd2;

  typedef struct packed {
    logic             due;
    logic             pressed;
    logic             event_valid;
    logic [1:0]       event_kind;
    logic [SCR_W-1:0] coord_x;
    logic [SCR_W-1:0] coord_y;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [1:0]       touch_state;
  } tick_result_t;

  // --------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // --------------------------------------------------------------------------
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [15:0]      elapsed = '0;
  logic             pen_down = 1'b0;
  logic [RAW_W-1:0] sample_x = '0;
  logic [RAW_W-1:0] sample_y = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             due, pressed, event_valid;
  logic [1:0]       event_kind, touch_state;
  logic [SCR_W-1:0] coord_x, coord_y;
  logic [RAW_W-1:0] raw_x, raw_y;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [4:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;

  touch_event_sampler_core DUT (
    .clk, .rst,
    .in_valid, .in_stall, .elapsed, .pen_down, .sample_x, .sample_y,
    .out_valid, .out_stall, .due, .pressed, .event_valid, .event_kind,
    .coord_x, .coord_y, .raw_x, .raw_y, .touch_state,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench-side copy of the sampler: registers and state
  // --------------------------------------------------------------------------
  logic [RAW_W-1:0] cfg_max_x  = 12'd3942;
  logic [RAW_W-1:0] cfg_max_y  = 12'd3853;
  logic [SCR_W-1:0] cfg_scr_w  = 10'd320;
  logic [SCR_W-1:0] cfg_scr_h  = 10'd240;
  logic [15:0]      cfg_period = 16'd20;
  logic [31:0]      acc_time   = '0;
  logic [1:0]       touch_phase = ST_UNTOUCHED;
  logic [RAW_W-1:0] held_x = '0;
  logic [RAW_W-1:0] held_y = '0;

  tick_result_t expected_ticks[$];
  int errors = 0;
  int send_idle_pct = 0;   // chance per cycle that the sender holds back
  int stall_pct = 0;       // chance per cycle that the receiver stalls
  int hold_len = 0;        // forced receiver hold-off, consumed by the receiver

  // step = (max/screen)*10; coord = raw*10/step - 10, clamped 0..screen.
  // A screen that truncates the step to zero pins the coordinate at screen.
  function automatic logic [SCR_W-1:0] scale_axis(logic [RAW_W-1:0] raw,
                                                   logic [RAW_W-1:0] max_raw,
                                                   logic [SCR_W-1:0] scr);
    int step;
    int v;
    if (scr == 0) return '0;
    step = (int'(max_raw) / int'(scr)) * 10;
    if (step == 0) return scr;
    v = (int'(raw) * 10) / step - 10;
    if (v < 0) v = 0;
    if (v > int'(scr)) v = int'(scr);
    return SCR_W'(v);
  endfunction

  // Advance the bench state by one tick and return the result it implies.
  function automatic tick_result_t predict_tick(logic [15:0] dt, logic pen,
                                                logic [RAW_W-1:0] sx,
                                                logic [RAW_W-1:0] sy);
    tick_result_t r;
    logic [32:0] sum;
    r = '0;
    sum = {1'b0, acc_time} + 33'(dt);
    acc_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];   // saturate
    if (acc_time >= 32'(cfg_period)) begin
      acc_time -= 32'(cfg_period);
      r.due = 1'b1;
      if (pen) begin
        held_x = sx;
        held_y = sy;
        r.pressed = 1'b1;
        if (touch_phase != ST_TOUCHED && touch_phase != ST_RELEASED) begin
          touch_phase = ST_TOUCHED;
          r.event_valid = 1'b1;
          r.event_kind = EV_TOUCHED;
        end
      end else if (touch_phase == ST_TOUCHED) begin
        touch_phase = ST_RELEASED;
        r.event_valid = 1'b1;
        r.event_kind = EV_RELEASED;
      end else if (touch_phase == ST_RELEASED) begin
        touch_phase = ST_UNTOUCHED;
        r.event_valid = 1'b1;
        r.event_kind = EV_UNTOUCHED;
      end
    end
    r.coord_x = scale_axis(held_x, cfg_max_x, cfg_scr_w);
    r.coord_y = scale_axis(held_y, cfg_max_y, cfg_scr_h);
    r.raw_x = held_x;
    r.raw_y = held_y;
    r.touch_state = touch_phase;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: random stall, forced hold-off, and the per-field check
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t: result item with none expected, actual touch_state %0d",
                 $time, touch_state);
      end else begin
        want = expected_ticks.pop_front();
        check_field("due", want.due, due);
        check_field("pressed", want.pressed, pressed);
        check_field("event_valid", want.event_valid, event_valid);
        check_field("event_kind", want.event_kind, event_kind);
        check_field("coord_x", want.coord_x, coord_x);
        check_field("coord_y", want.coord_y, coord_y);
        check_field("raw_x", want.raw_x, raw_x);
        check_field("raw_y", want.raw_y, raw_y);
        check_field("touch_state", want.touch_state, touch_state);
      end
    end
    // A requested hold-off is counted out here, one cycle per edge
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: counts edges at which no item moves and no APB cycle runs
  int quiet = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Shared drivers
  // --------------------------------------------------------------------------

  // Offer one tick, wait for it to be taken, then log its expected result.
  // valid stays high after acceptance so a back-to-back item never toggles it
  // within one time step; drain_results lowers it when traffic pauses.
  task automatic send_tick(logic [15:0] dt, logic pen,
                           logic [RAW_W-1:0] sx, logic [RAW_W-1:0] sy);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    elapsed  <= dt;
    pen_down <= pen;
    sample_x <= sx;
    sample_y <= sy;
    do @(posedge clk); while (in_stall);
    expected_ticks.push_back(predict_tick(dt, pen, sx, sy));
  endtask

  // Stop offering and wait until every expected result has come out and the
  // block has had time to settle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (ITEM_CYCLES + 4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready.
  task automatic write_reg(cfg_reg_e idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAX_RAW_X:     cfg_max_x  = value[RAW_W-1:0];
      REG_MAX_RAW_Y:     cfg_max_y  = value[RAW_W-1:0];
      REG_SCREEN_WIDTH:  cfg_scr_w  = value[SCR_W-1:0];
      REG_SCREEN_HEIGHT: cfg_scr_h  = value[SCR_W-1:0];
      REG_SAMPLE_PERIOD: cfg_period = value[15:0];
      default: ;
    endcase
  endtask

  // Only called with the block idle
  task automatic configure(int mx, int my, int sw, int sh, int sp);
    drain_results();
    write_reg(REG_MAX_RAW_X, 32'(mx));
    write_reg(REG_MAX_RAW_Y, 32'(my));
    write_reg(REG_SCREEN_WIDTH, 32'(sw));
    write_reg(REG_SCREEN_HEIGHT, 32'(sh));
    write_reg(REG_SAMPLE_PERIOD, 32'(sp));
  endtask

  // Value in lo..hi with extra weight on both ends
  function automatic int pick_range(int lo, int hi);
    int r;
    r = $urandom_range(7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return $urandom_range(hi, lo);
  endfunction

  // Mostly near the period so samples keep happening; some zero, max, random
  function automatic logic [15:0] pick_elapsed(int period);
    int r;
    int v;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return 16'hFFFF;
    if (r == 2) return 16'($urandom);
    v = $urandom_range(period + period / 2, period / 2);
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Full press/release cycle at reset settings: ticks short of a period,
  // press at the extreme samples, stay touched, release, return to untouched,
  // plus an idle sample with the pen up.
  task automatic test_touch_sequence();
    send_tick(16'd0, 1'b1, 12'hFFF, 12'hFFF);       // nothing accumulated
    send_tick(16'd19, 1'b1, 12'hFFF, 12'hFFF);      // one short of period
    send_tick(16'd1, 1'b1, 12'hFFF, 12'hFFF);       // touched, clamps high
    send_tick(16'd20, 1'b1, 12'h000, 12'h000);      // still touched, clamps low
    send_tick(16'd20, 1'b1, 12'h800, 12'h3E8);      // mid-screen in X
    send_tick(16'd25, 1'b0, 12'h000, 12'h000);      // released
    send_tick(16'd15, 1'b0, 12'h555, 12'hAAA);      // untouched via leftover
    send_tick(16'd20, 1'b0, 12'hAAA, 12'h555);      // sampled, no change
    send_tick(16'hFFFF, 1'b1, 12'h123, 12'hFED);    // big tick, touched again
    send_tick(16'd0, 1'b0, 12'h000, 12'h000);       // leftover time still due
  endtask

  // Register extremes: huge step (coords pinned low), zero step (coords at
  // screen), step of ten (clamp at a one-pixel screen), longest period.
  task automatic test_scale_extremes();
    configure(4095, 4095, 1, 1, 1);
    send_tick(16'd1, 1'b1, 12'hFFF, 12'h000);
    send_tick(16'd0, 1'b0, 12'h000, 12'hFFF);
    configure(1, 1, 1023, 1023, 65535);
    send_tick(16'hFFFE, 1'b1, 12'h064, 12'h0C8);    // one short of period
    send_tick(16'hFFFF, 1'b1, 12'h064, 12'h0C8);
    configure(1, 4095, 1, 1023, 65535);
    send_tick(16'd0, 1'b1, 12'hFFF, 12'hFFF);
    send_tick(16'hFFFF, 1'b1, 12'hFFF, 12'hFFF);
    send_tick(16'hFFFF, 1'b0, 12'h001, 12'h001);
    configure(3942, 3853, 320, 240, 20);
  endtask

  // Random registers, then press/release runs with random samples under the
  // given idling mix.
  task automatic test_random_traffic(int idle_in, int stall_out, int n);
    int period;
    logic pen;
    logic [RAW_W-1:0] sx, sy;
    period = ($urandom_range(7) == 0) ? pick_range(1, 65535) : $urandom_range(200, 1);
    configure(pick_range(1, 4095), pick_range(1, 4095),
              pick_range(1, 1023), pick_range(1, 1023), period);
    send_idle_pct = idle_in;
    stall_pct = stall_out;
    pen = 1'b0;
    for (int i = 0; i < n; i++) begin
      // pen level runs for a few ticks so the state machine cycles fully
      if ($urandom_range(4) == 0) pen = ~pen;
      sx = 12'(pick_range(0, 4095));
      sy = 12'(pick_range(0, 4095));
      send_tick(pick_elapsed(period), pen, sx, sy);
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  // Receiver holds off a long stretch while the sender keeps offering: one
  // item waits in the output register, one is in flight, the input stalls.
  // Then the sender pauses until everything is out and traffic resumes.
  task automatic test_backpressure();
    configure(3942, 3853, 320, 240, 20);
    hold_len = HOLD_CYCLES;
    for (int i = 0; i < 8; i++) begin
      send_tick(16'd20, 1'(i % 3 != 2), 12'($urandom), 12'($urandom));
    end
    drain_results();
    stall_pct = 50;
    for (int i = 0; i < 6; i++) begin
      send_tick(16'd20, 1'(i < 2), 12'($urandom), 12'($urandom));
    end
    stall_pct = 0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_touch_sequence();
    test_scale_extremes();
    test_random_traffic(0, 0, 150);
    test_random_traffic(86, 0, 150);
    test_random_traffic(0, 86, 150);
    test_random_traffic(30, 30, 150);
    test_backpressure();
    drain_results();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
